// ----- rtl/modbus_rtu_register_slave_macros.svh -----
// Assertion macros for the RTL of the register slave.
// Used by files that carry concurrent checks; no other dependencies.
`ifndef MODBUS_RTU_REGISTER_SLAVE_MACROS_SVH
`define MODBUS_RTU_REGISTER_SLAVE_MACROS_SVH
`ifndef SYNTHESIS
// Check that applies only while reset is low.
`define MRS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that applies at every edge, reset included.
`define MRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MRS_ASSERT(lbl, clk, rst, prop, msg)
`define MRS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/mrs_pkg.sv -----
// Package of the register slave: codes, command and status structs, CRC step.
// No dependencies.
`timescale 1ns / 1ps
package mrs_pkg;

   localparam logic [7:0] FN_READ_HOLD    = 8'h03;
   localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;
   localparam logic [7:0] FN_WRITE_MULTI  = 8'h10;

   localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'h01;
   localparam logic [7:0] EXC_ILLEGAL_ADDRESS  = 8'h02;
   localparam logic [7:0] EXC_DEVICE_FAILURE   = 8'h04;
   localparam logic [7:0] EXC_FLAG             = 8'h80;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [7:0] SLAVE_ADDR_RESET = 8'h01;
   localparam int         HDR_BYTES        = 6;

   typedef logic [1:0] resp_kind_type;
   localparam resp_kind_type RESP_EXC  = 2'd0;
   localparam resp_kind_type RESP_ECHO = 2'd1;
   localparam resp_kind_type RESP_READ = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic          rx_ready;
      logic          clr_step;
      logic          start_resp;
      resp_kind_type kind;
      logic [7:0]    exc_code;
      logic          hr_wr_single;
      logic          fr_rd_lo;
      logic          fr_rd_hi;
      logic          hr_wr_multi;
      logic          hr_rd;
      logic          emit;
   } mrs_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic frame_done;
      logic clr_last;
      logic len_ok;
      logic addr_ok;
      logic fn_ok;
      logic start_ok;
      logic crc_ok;
      logic is_read;
      logic is_single;
      logic read_ok;
      logic single_ok;
      logic multi_ok;
      logic multi_last;
      logic need_word;
      logic last_byte;
      logic out_free;
   } mrs_status_type;

   // One byte of CRC-16/MODBUS, bit by bit.
   function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- rtl/mrs_if.sv -----
// Valid/ready channel interfaces for request bytes and response bytes.
// No dependencies.
`timescale 1ns / 1ps
interface mrs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_end;
   modport source (output valid, output rx_byte, output frame_end, input ready);
   modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mrs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       tx_last;
   modport source (output valid, output tx_byte, output tx_last, input ready);
   modport sink (input valid, input tx_byte, input tx_last, output ready);
endinterface

// ----- rtl/mrs_ctrl.sv -----
// Controller state machine of the register slave.
// Depends on mrs_pkg for the command and status structs and codes.
`timescale 1ns / 1ps
module mrs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  mrs_pkg::mrs_status_type st,
   output mrs_pkg::mrs_cmd_type    cmd
);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_RX    = 4'd1;
   localparam logic [3:0] S_CHECK = 4'd2;
   localparam logic [3:0] S_EMIT  = 4'd3;
   localparam logic [3:0] S_HRD   = 4'd4;
   localparam logic [3:0] S_HEMIT = 4'd5;
   localparam logic [3:0] S_WLO   = 4'd6;
   localparam logic [3:0] S_WHI   = 4'd7;
   localparam logic [3:0] S_WWR   = 4'd8;

   logic [3:0] state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (st.clr_last) state_in = S_RX;
         end
         S_RX: begin
            cmd.rx_ready = 1'b1;
            if (st.frame_done) state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.kind     = mrs_pkg::RESP_EXC;
            cmd.exc_code = mrs_pkg::EXC_ILLEGAL_ADDRESS;
            state_in     = S_EMIT;
            if (!st.len_ok || !st.addr_ok) begin
               state_in = S_RX;
            end else if (!st.fn_ok) begin
               cmd.start_resp = 1'b1;
               cmd.exc_code   = mrs_pkg::EXC_ILLEGAL_FUNCTION;
            end else if (!st.start_ok) begin
               cmd.start_resp = 1'b1;
            end else if (!st.crc_ok) begin
               cmd.start_resp = 1'b1;
               cmd.exc_code   = mrs_pkg::EXC_DEVICE_FAILURE;
            end else if (st.is_read) begin
               cmd.start_resp = 1'b1;
               if (st.read_ok) cmd.kind = mrs_pkg::RESP_READ;
            end else if (st.is_single) begin
               cmd.start_resp = 1'b1;
               if (st.single_ok) begin
                  cmd.kind         = mrs_pkg::RESP_ECHO;
                  cmd.hr_wr_single = 1'b1;
               end
            end else begin
               cmd.start_resp = 1'b1;
               if (st.multi_ok) begin
                  cmd.kind = mrs_pkg::RESP_ECHO;
                  state_in = S_WLO;
               end
            end
         end
         S_EMIT: begin
            if (st.need_word) begin
               state_in = S_HRD;
            end else if (st.out_free) begin
               cmd.emit = 1'b1;
               if (st.last_byte) state_in = S_RX;
            end
         end
         S_HRD: begin
            cmd.hr_rd = 1'b1;
            state_in  = S_HEMIT;
         end
         S_HEMIT: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_EMIT;
            end
         end
         S_WLO: begin
            cmd.fr_rd_lo = 1'b1;
            state_in     = S_WHI;
         end
         S_WHI: begin
            cmd.fr_rd_hi = 1'b1;
            state_in     = S_WWR;
         end
         S_WWR: begin
            cmd.hr_wr_multi = 1'b1;
            state_in        = st.multi_last ? S_EMIT : S_WLO;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/mrs_datapath.sv -----
// Datapath of the register slave: frame buffer, register table, CRC, response.
// Depends on mrs_pkg, the channel interfaces and the assertion macros.
`timescale 1ns / 1ps
`include "modbus_rtu_register_slave_macros.svh"
module mrs_datapath #(
   parameter int FRAME_MAX     = 256,
   parameter int REG_COUNT     = 1024,
   parameter int MAX_READ_REGS = 29
) (
   input  logic                    clock,
   input  logic                    reset,
   mrs_req_if.sink                 req,
   mrs_rsp_if.source               rsp,
   input  logic                    csr_wr_en,
   input  logic [7:0]              csr_wr_data,
   input  mrs_pkg::mrs_cmd_type    cmd,
   output mrs_pkg::mrs_status_type st
);

   localparam int FW = $clog2(FRAME_MAX);
   localparam int CW = $clog2(FRAME_MAX + 2);
   localparam int AW = $clog2(REG_COUNT);
   localparam int IW = (FW > 5) ? FW : 5;

   logic [7:0]  slave_ff;
   logic [CW-1:0] count_ff, count_in, len_ff;
   logic [7:0]  hdr_ff [mrs_pkg::HDR_BYTES];
   logic [7:0]  tail0_ff, tail1_ff;
   logic [15:0] rx_crc_ff;
   logic [7:0]  fr_mem [FRAME_MAX];
   logic [7:0]  fr_rdata_ff, lo_ff;
   logic [15:0] hr_mem [REG_COUNT];
   logic [15:0] hr_rdata_ff;
   logic [AW-1:0] clr_ff;
   logic [IW-1:0] idx_ff;
   logic        accept;
   logic        store;
   mrs_pkg::resp_kind_type kind_ff;
   logic [7:0]  code_ff;
   logic [5:0]  k_ff, body_len;
   logic [15:0] tx_crc_ff;
   logic        rsp_valid_ff;
   logic [7:0]  tx_byte_ff, tx_sel;
   logic        tx_last_ff;
   logic [15:0] start_addr, num;
   logic [16:0] start_plus_num, hr_addr_full;
   logic [17:0] multi_need;
   logic [IW+1:0] fr_addr_full;
   logic [FW-1:0] fr_raddr;
   logic [AW-1:0] hr_waddr;
   logic [15:0] hr_wdata;
   logic        hr_we;

   assign accept     = req.valid && req.ready;
   assign store      = count_ff < CW'(FRAME_MAX);
   assign count_in   = store ? (count_ff + CW'(1)) : CW'(FRAME_MAX + 1);
   assign start_addr = {hdr_ff[2], hdr_ff[3]};
   assign num        = {hdr_ff[4], hdr_ff[5]};
   assign req.ready  = cmd.rx_ready;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         slave_ff <= mrs_pkg::SLAVE_ADDR_RESET;
      end else if (csr_wr_en) begin
         slave_ff <= csr_wr_data;
      end
   end

   // Receive side: byte count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= req.frame_end ? '0 : count_in;
      end
   end

   // Frame length, header bytes, the last two bytes and a CRC that trails them by two bytes.
   always_ff @(posedge clock) begin
      if (accept) begin
         if (req.frame_end) len_ff <= count_in;
         if (count_ff < CW'(mrs_pkg::HDR_BYTES)) hdr_ff[count_ff[2:0]] <= req.rx_byte;
         if (store) begin
            tail0_ff <= req.rx_byte;
            tail1_ff <= tail0_ff;
            if (count_ff == '0) begin
               rx_crc_ff <= mrs_pkg::CRC_INIT;
            end else if (count_ff >= CW'(2)) begin
               rx_crc_ff <= mrs_pkg::crc16_update(rx_crc_ff, tail1_ff);
            end
         end
      end
   end

   // Frame buffer.
   assign fr_addr_full = {1'b0, idx_ff, 1'b0} + (cmd.fr_rd_hi ? (IW+2)'(8) : (IW+2)'(7));
   assign fr_raddr     = fr_addr_full[FW-1:0];

   always_ff @(posedge clock) begin
      if (accept && store) fr_mem[count_ff[FW-1:0]] <= req.rx_byte;
      if (cmd.fr_rd_lo || cmd.fr_rd_hi) fr_rdata_ff <= fr_mem[fr_raddr];
      if (cmd.fr_rd_hi) lo_ff <= fr_rdata_ff;
   end

   // Register table, cleared by a pass after reset.
   assign hr_addr_full = {1'b0, start_addr} + 17'(idx_ff);
   assign hr_we        = cmd.clr_step || cmd.hr_wr_single || cmd.hr_wr_multi;

   always_comb begin
      if (cmd.clr_step) begin
         hr_waddr = clr_ff;
         hr_wdata = '0;
      end else if (cmd.hr_wr_single) begin
         hr_waddr = start_addr[AW-1:0];
         hr_wdata = num;
      end else begin
         hr_waddr = hr_addr_full[AW-1:0];
         hr_wdata = {fr_rdata_ff, lo_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (hr_we) hr_mem[hr_waddr] <= hr_wdata;
      if (cmd.hr_rd) hr_rdata_ff <= hr_mem[hr_addr_full[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   // Register loop index.
   always_ff @(posedge clock) begin
      if (cmd.start_resp) begin
         idx_ff <= '0;
      end else if (cmd.hr_rd || cmd.hr_wr_multi) begin
         idx_ff <= idx_ff + IW'(1);
      end
   end

   // Request checks and response status.
   assign start_plus_num = {1'b0, start_addr} + {1'b0, num};
   assign multi_need     = {1'b0, num, 1'b0} + 18'd9;

   always_comb begin
      st.frame_done = accept && req.frame_end;
      st.clr_last   = clr_ff == AW'(REG_COUNT - 1);
      st.len_ok     = (len_ff >= CW'(4)) && (len_ff <= CW'(FRAME_MAX));
      st.addr_ok    = hdr_ff[0] == slave_ff;
      st.is_read    = hdr_ff[1] == mrs_pkg::FN_READ_HOLD;
      st.is_single  = hdr_ff[1] == mrs_pkg::FN_WRITE_SINGLE;
      st.fn_ok      = st.is_read || st.is_single || (hdr_ff[1] == mrs_pkg::FN_WRITE_MULTI);
      st.start_ok   = {1'b0, start_addr} < 17'(REG_COUNT);
      st.crc_ok     = (tail1_ff == rx_crc_ff[7:0]) && (tail0_ff == rx_crc_ff[15:8]);
      st.read_ok    = (len_ff >= CW'(8)) && (num != '0) && (num <= 16'(MAX_READ_REGS))
                      && (start_plus_num <= 17'(REG_COUNT));
      st.single_ok  = len_ff >= CW'(8);
      st.multi_ok   = (len_ff >= CW'(9)) && (num != '0)
                      && (start_plus_num <= 17'(REG_COUNT)) && (multi_need <= 18'(len_ff));
      st.multi_last = (16'(idx_ff) + 16'd1) == num;
      st.last_byte  = k_ff == (body_len + 6'd1);
      st.need_word  = (kind_ff == mrs_pkg::RESP_READ) && (k_ff >= 6'd3)
                      && (k_ff < body_len) && k_ff[0];
      st.out_free   = !rsp_valid_ff || rsp.ready;
   end

   // Response byte selection.
   always_comb begin
      unique case (kind_ff)
         mrs_pkg::RESP_ECHO: body_len = 6'd6;
         mrs_pkg::RESP_READ: body_len = 6'd3 + {num[4:0], 1'b0};
         default:            body_len = 6'd3;
      endcase
   end

   always_comb begin
      tx_sel = tx_crc_ff[15:8];
      if (k_ff < body_len) begin
         if (k_ff == 6'd0) begin
            tx_sel = hdr_ff[0];
         end else if (kind_ff == mrs_pkg::RESP_ECHO) begin
            tx_sel = hdr_ff[k_ff[2:0]];
         end else if (k_ff == 6'd1) begin
            tx_sel = (kind_ff == mrs_pkg::RESP_EXC) ? (hdr_ff[1] | mrs_pkg::EXC_FLAG)
                                                     : hdr_ff[1];
         end else if (kind_ff == mrs_pkg::RESP_EXC) begin
            tx_sel = code_ff;
         end else if (k_ff == 6'd2) begin
            tx_sel = {num[6:0], 1'b0};
         end else begin
            tx_sel = k_ff[0] ? hr_rdata_ff[7:0] : hr_rdata_ff[15:8];
         end
      end else if (k_ff == body_len) begin
         tx_sel = tx_crc_ff[7:0];
      end
   end

   // Response sequencing and running CRC.
   always_ff @(posedge clock) begin
      if (cmd.start_resp) begin
         kind_ff   <= cmd.kind;
         code_ff   <= cmd.exc_code;
         k_ff      <= '0;
         tx_crc_ff <= mrs_pkg::CRC_INIT;
      end else if (cmd.emit) begin
         k_ff <= k_ff + 6'd1;
         if (k_ff < body_len) tx_crc_ff <= mrs_pkg::crc16_update(tx_crc_ff, tx_sel);
      end
      if (cmd.emit) begin
         tx_byte_ff <= tx_sel;
         tx_last_ff <= st.last_byte;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.tx_byte = tx_byte_ff;
   assign rsp.tx_last = tx_last_ff;

   `MRS_ASSERT(a_emit_free, clock, reset, cmd.emit |-> st.out_free, "emit into full output")
   `MRS_ASSERT(a_wr_in_table, clock, reset, cmd.hr_wr_multi |-> hr_addr_full < 17'(REG_COUNT), "bad write")
   `MRS_ASSERT(a_end_stalls, clock, reset, st.frame_done |=> !req.ready, "ready after frame end")
   `MRS_ASSERT(a_no_rx_emit, clock, reset, req.ready |-> !cmd.emit && !hr_we, "work during receive")

endmodule

// ----- rtl/modbus_rtu_register_slave.sv -----
// Modbus RTU holding-register slave, top level.
// Depends on mrs_pkg, mrs_if, mrs_ctrl and mrs_datapath.
`timescale 1ns / 1ps
// Request bytes are taken one per cycle while a frame is being received. After the byte
// marked frame_end, ready drops while the frame is handled: the checks, then for write
// multiple two frame-buffer reads and a table write per register, then the response
// (none for a bad length or slave address) at one byte per cycle, with a table read before
// each register for read holding registers. A stalled response channel stretches this.
// After reset the register table is cleared by a pass over all REG_COUNT entries during
// which no request byte is taken; csr writes are taken at any time.
module modbus_rtu_register_slave #(
   parameter int FRAME_MAX     = 256,
   parameter int REG_COUNT     = 1024,
   parameter int MAX_READ_REGS = 29
) (
   input  logic       clock,
   input  logic       reset,
   mrs_req_if.sink    req,
   mrs_rsp_if.source  rsp,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   mrs_pkg::mrs_cmd_type    cmd;
   mrs_pkg::mrs_status_type st;

   // Sequencer.
   mrs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd)
   );

   // Buffers, table, CRC and response path.
   mrs_datapath #(
      .FRAME_MAX     (FRAME_MAX),
      .REG_COUNT     (REG_COUNT),
      .MAX_READ_REGS (MAX_READ_REGS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .st          (st)
   );

endmodule
